// ----- rtl/core/qlie_pkg.sv -----
// Package for the quoted list item extractor.
// Holds the character codes, register indexes and the result beat type.
// Depends on nothing; every core file refers to it by scoped names.
package qlie_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] TARGET_INDEX_RESET = 8'd0;
    localparam logic [7:0] MAX_CHARS_RESET    = 8'd32;

    localparam int unsigned COMMA_W = 9;
    localparam logic [COMMA_W-1:0] COMMA_SAT = '1;
    localparam logic [7:0] GIVEN_SAT = 8'hFF;

    typedef enum logic [7:0] {
        REG_TARGET_INDEX = 8'd0,
        REG_MAX_CHARS    = 8'd1
    } reg_index_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] name_char;
        logic       char_valid;
        logic       done_res;
        logic [7:0] name_length;
    } result_t;

endpackage

// ----- rtl/core/qlie_parse.sv -----
// Parser state and per-byte decision logic of the quoted list item extractor.
// Uses qlie_pkg for character codes and the result beat type.
module qlie_parse (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          ch,
    input  logic                start_req,
    input  logic                last,
    input  logic [7:0]          target_index,
    input  logic [7:0]          max_chars,
    output logic                push,
    output qlie_pkg::result_t   result
);

    logic                            in_quotes_reg, in_quotes_next;
    logic [qlie_pkg::COMMA_W-1:0]    comma_count_reg, comma_count_next;
    logic [7:0]                      given_count_reg, given_count_next;
    logic                            finished_reg;

    logic                            eff_quotes;
    logic [qlie_pkg::COMMA_W-1:0]    eff_comma;
    logic [7:0]                      eff_given;
    logic                            eff_finished;
    logic [qlie_pkg::COMMA_W-1:0]    target_ext;
    logic                            gave;
    logic                            stop;

    // A start byte sees cleared state.
    assign eff_quotes   = start_req ? 1'b0 : in_quotes_reg;
    assign eff_comma    = start_req ? '0 : comma_count_reg;
    assign eff_given    = start_req ? '0 : given_count_reg;
    assign eff_finished = start_req ? 1'b0 : finished_reg;
    assign target_ext   = {1'b0, target_index};

    always_comb begin
        in_quotes_next   = eff_quotes;
        comma_count_next = eff_comma;
        given_count_next = eff_given;
        gave             = 1'b0;
        stop             = 1'b0;
        if (ch == qlie_pkg::CH_NUL) begin
            stop = 1'b1;
        end else if (ch == qlie_pkg::CH_AT && eff_quotes && eff_comma == target_ext) begin
            stop = 1'b1;
        end else begin
            if (ch == qlie_pkg::CH_QUOTE) begin
                in_quotes_next = !eff_quotes;
            end else if (ch != qlie_pkg::CH_LBRACK && ch != qlie_pkg::CH_RBRACK) begin
                if (ch == qlie_pkg::CH_COMMA && !eff_quotes
                    && eff_comma != qlie_pkg::COMMA_SAT) begin
                    comma_count_next = eff_comma + 1'b1;
                end
                if (eff_quotes && comma_count_next == target_ext) begin
                    gave = 1'b1;
                    if (eff_given != qlie_pkg::GIVEN_SAT) begin
                        given_count_next = eff_given + 1'b1;
                    end
                end
            end
            if (comma_count_next > target_ext || given_count_next >= max_chars) begin
                stop = 1'b1;
            end
        end
        if (last) begin
            stop = 1'b1;
        end
    end

    assign push = accept && !eff_finished && (gave || stop);

    always_comb begin
        result.name_char   = gave ? ch : 8'd0;
        result.char_valid  = gave;
        result.done_res    = stop;
        result.name_length = given_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg   <= 1'b0;
            comma_count_reg <= '0;
            given_count_reg <= '0;
            finished_reg    <= 1'b0;
        end else if (accept && !eff_finished) begin
            in_quotes_reg   <= in_quotes_next;
            comma_count_reg <= comma_count_next;
            given_count_reg <= given_count_next;
            finished_reg    <= stop;
        end
    end

endmodule

// ----- rtl/core/qlie_out_buf.sv -----
// Two-entry result buffer that decouples the parser from the result channel.
// Uses qlie_pkg for the result beat type.
module qlie_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  qlie_pkg::result_t   push_data,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output qlie_pkg::result_t   m_data,
    output logic [1:0]          fill
);

    qlie_pkg::result_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign m_data  = slot_reg[rd_ptr_reg];
    assign fill    = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/quoted_list_item_extractor_top.sv -----
// Top level of the quoted list item extractor.
// Depends on qlie_pkg, qlie_parse and qlie_out_buf.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_ch, s_start_req, s_last
//   m_        out        m_valid / m_ready    m_name_char, m_char_valid,
//                                             m_done_res, m_name_length
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input beat is taken every cycle while s_ready is high. The parser
// state updates at the edge that accepts a beat, and any result goes into
// a two-entry buffer, so a result is registered before it is shown on m_.
// s_ready drops only while both buffer entries hold results not yet taken.
// Reset (aresetn low at a clock edge) clears the parser state and the buffer
// and loads the register defaults: item zero, at most 32 characters.
// The configuration port is always ready.
module quoted_list_item_extractor_top (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_start_req,
    input  logic       s_last,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_name_char,
    output logic       m_char_valid,
    output logic       m_done_res,
    output logic [7:0] m_name_length,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]        target_index_reg;
    logic [7:0]        max_chars_reg;
    logic              accept;
    logic              push;
    logic              buf_full;
    logic [1:0]        buf_fill;
    qlie_pkg::result_t parse_result;
    qlie_pkg::result_t out_data;

    assign cfg_ready = 1'b1;

    // Register writes; an index outside the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_index_reg <= qlie_pkg::TARGET_INDEX_RESET;
            max_chars_reg    <= qlie_pkg::MAX_CHARS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                qlie_pkg::REG_TARGET_INDEX: target_index_reg <= cfg_data;
                qlie_pkg::REG_MAX_CHARS:    max_chars_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // A beat is taken whenever the result buffer has room for its result.
    assign s_ready = !buf_full;
    assign accept  = s_valid && s_ready;

    qlie_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .ch           (s_ch),
        .start_req    (s_start_req),
        .last         (s_last),
        .target_index (target_index_reg),
        .max_chars    (max_chars_reg),
        .push         (push),
        .result       (parse_result)
    );

    qlie_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (parse_result),
        .full      (buf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_data),
        .fill      (buf_fill)
    );

    assign m_name_char   = out_data.name_char;
    assign m_char_valid  = out_data.char_valid;
    assign m_done_res    = out_data.done_res;
    assign m_name_length = out_data.name_length;

    // The buffer never holds more than two results.
    assert property (@(posedge aclk) disable iff (!aresetn) buf_fill != 2'd3)
        else $error("result buffer overfilled");

    // A result is only produced for a beat that was accepted.
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> accept)
        else $error("result produced without an accepted beat");

    // A result that gives no character must be the one that ends extraction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_char_valid) |-> m_done_res)
        else $error("empty result that does not end extraction");

    // A given character always counts toward the length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_char_valid) |-> (m_name_length != 8'd0))
        else $error("character given with zero length");

endmodule
